// File: sv/array_bst_insert_search_core_defines.svh
// Assertion macros for the array BST core.
`ifndef ARRAY_BST_INSERT_SEARCH_CORE_DEFINES_SVH
`define ARRAY_BST_INSERT_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ABST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/abst_pkg.sv
`default_nettype none

package abst_pkg;

  localparam int TREE_SLOTS = 63;
  localparam int KEY_BITS   = 16;

  // Slot address, and walk position wide enough to hold 2*TREE_SLOTS.
  localparam int SLOT_W = $clog2(TREE_SLOTS);
  localparam int POS_W  = $clog2(TREE_SLOTS + 1) + 1;

  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

endpackage

`default_nettype wire

// File: sv/array_bst_insert_search_core.sv
// Array-held binary search tree: insert and lookup of keys.
// Request channel: in_valid_i / in_stall_o with req_type_i (0 insert,
// 1 lookup) and key_i; a request is taken when in_valid_i is high and
// in_stall_o is low. Result channel: out_valid_o / out_stall_i with
// status_o, min_key_o, max_key_o and tree_empty_o, one result per request.
// One request is in flight at a time. The walk runs in the key memory, each
// tree level in the states S_WALK (address) and S_CMP (compare of the
// registered read). A request that visits L occupied slots shows its result
// after its walk and the commit in S_RESP; L is at most 6 for 63 slots. After
// commit the core returns to S_IDLE and then takes the next request.
// The result sits in an output register; while it waits under out_stall_i
// the core already takes and walks the next request, and only holds that
// request's commit until the output register frees up.
// Reset clears the occupied bits, min/max and the output register; the tree
// is empty at once, no clearing pass is needed. Key memory is not reset.
// Inserts write the memory only at commit, after the walk is finished, so a
// read and a write of the same slot never overlap.
`default_nettype none

`include "array_bst_insert_search_core_defines.svh"

module array_bst_insert_search_core
  import abst_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic                req_type_i,
  input  wire logic [KEY_BITS-1:0] key_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [STATUS_W-1:0] status_o,
  output      logic [KEY_BITS-1:0] min_key_o,
  output      logic [KEY_BITS-1:0] max_key_o,
  output      logic                tree_empty_o
);

  typedef enum logic [1:0] {
    S_IDLE,   // waiting for a request
    S_WALK,   // check position, issue memory read
    S_CMP,    // compare registered slot key, step to child
    S_RESP    // commit insert and load output register
  } state_e;

  state_e              state_q;
  logic                req_q;
  logic [KEY_BITS-1:0] key_q;
  logic [POS_W-1:0]    pos_q;
  logic [STATUS_W-1:0] stat_q;

  // Occupied bit per slot, cleared at reset.
  logic [TREE_SLOTS-1:0] used_q;
  logic [KEY_BITS-1:0]   smallest_q, largest_q;
  logic                  any_q;

  // Output register.
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [KEY_BITS-1:0] out_min_q, out_max_q;
  logic                out_empty_q;

  // Key memory, one synchronous read port, one write port.
  logic [KEY_BITS-1:0] key_mem [TREE_SLOTS];
  logic [KEY_BITS-1:0] rd_data_q;
  logic                rd_en;
  logic                wr_en;
  logic [SLOT_W-1:0]   slot_addr;

  logic                in_accept;
  logic                pos_in_range;
  logic                pos_used;
  logic                out_free;
  logic                commit;
  logic                do_insert;
  logic [POS_W-1:0]    pos_x2;
  logic [KEY_BITS-1:0] smallest_d, largest_d;
  logic                any_d;

  assign in_accept    = in_valid_i && !in_stall_o;
  assign in_stall_o   = (state_q != S_IDLE);
  assign pos_in_range = (pos_q < POS_W'(TREE_SLOTS));
  assign slot_addr    = pos_q[SLOT_W-1:0];
  assign pos_used     = pos_in_range && used_q[slot_addr];
  assign pos_x2       = {pos_q[POS_W-2:0], 1'b0};

  assign out_free  = !out_valid_q || !out_stall_i;
  assign commit    = (state_q == S_RESP) && out_free;
  assign do_insert = commit && (stat_q == ST_INSERTED);

  assign rd_en = (state_q == S_WALK) && pos_used;
  assign wr_en = do_insert;

  // Min/max after this request's insert, if any.
  always_comb begin
    smallest_d = smallest_q;
    largest_d  = largest_q;
    any_d      = any_q;
    if (do_insert) begin
      any_d = 1'b1;
      if (!any_q || key_q < smallest_q) begin
        smallest_d = key_q;
      end
      if (!any_q || key_q > largest_q) begin
        largest_d = key_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[slot_addr] <= key_q;
    end
    if (rd_en) begin
      rd_data_q <= key_mem[slot_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= REQ_INSERT;
      key_q        <= '0;
      pos_q        <= '0;
      stat_q       <= ST_ABSENT;
      used_q       <= '0;
      smallest_q   <= '0;
      largest_q    <= '0;
      any_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_ABSENT;
      out_min_q    <= '0;
      out_max_q    <= '0;
      out_empty_q  <= 1'b1;
    end else begin
      // a commit in the same cycle reloads the register instead
      if (out_valid_q && !out_stall_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            req_q   <= req_type_i;
            key_q   <= key_i;
            pos_q   <= '0;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (!pos_in_range) begin
            // walked off the array
            stat_q  <= (req_q == REQ_INSERT) ? ST_DROPPED : ST_ABSENT;
            state_q <= S_RESP;
          end else if (!pos_used) begin
            stat_q  <= (req_q == REQ_INSERT) ? ST_INSERTED : ST_ABSENT;
            state_q <= S_RESP;
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_data_q == key_q) begin
            stat_q  <= (req_q == REQ_INSERT) ? ST_DUPLICATE : ST_FOUND;
            state_q <= S_RESP;
          end else begin
            pos_q   <= (rd_data_q < key_q) ? pos_x2 + POS_W'(2) : pos_x2 + POS_W'(1);
            state_q <= S_WALK;
          end
        end
        S_RESP: begin
          if (commit) begin
            if (do_insert) begin
              used_q[slot_addr] <= 1'b1;
            end
            smallest_q   <= smallest_d;
            largest_q    <= largest_d;
            any_q        <= any_d;
            out_valid_q  <= 1'b1;
            out_status_q <= stat_q;
            out_min_q    <= any_d ? smallest_d : '0;
            out_max_q    <= any_d ? largest_d : '0;
            out_empty_q  <= !any_d;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign min_key_o    = out_min_q;
  assign max_key_o    = out_max_q;
  assign tree_empty_o = out_empty_q;

  // A new result is only ever loaded from the commit state.
  `ABST_ASSERT_NOW(a_load_from_resp, clk_i, rst_ni, $rose(out_valid_q),
                   $past(state_q == S_RESP), "result loaded outside commit")

  // A non-empty result never shows min above max.
  `ABST_ASSERT_NOW(a_min_le_max, clk_i, rst_ni, out_valid_q && !out_empty_q,
                   out_min_q <= out_max_q, "min key above max key")

  // An insert always lands on a slot that was free.
  `ABST_ASSERT_NOW(a_insert_free_slot, clk_i, rst_ni, do_insert,
                   pos_in_range && !used_q[slot_addr], "insert into occupied slot")

  // An accepted request starts its walk at the root.
  `ABST_ASSERT_NEXT(a_walk_from_root, clk_i, rst_ni, in_accept,
                    (state_q == S_WALK) && (pos_q == '0), "walk not started at root")

endmodule

`default_nettype wire
